[sv/density_grid_bilinear_sampler_defines.svh]
// assertion macros shared by the checker
`ifndef DENSITY_GRID_BILINEAR_SAMPLER_DEFINES_SVH
`define DENSITY_GRID_BILINEAR_SAMPLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DGBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DGBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dgbs_pkg.sv]
`default_nettype none

package dgbs_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_SAMPLE = 2'd0;
	localparam func_t FUNC_WRITE  = 2'd1;
	localparam func_t FUNC_CLEAR  = 2'd2;
	localparam func_t FUNC_NOP    = 2'd3;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_GRID_WIDTH    = 2'd0;
	localparam reg_idx_t REG_GRID_HEIGHT   = 2'd1;
	localparam reg_idx_t REG_INV_CELL_SIZE = 2'd2;

	localparam logic [15:0] FULL_DENSITY  = 16'd65280;
	localparam logic [18:0] INV_CELL_UNIT = 19'd65536;
	localparam logic [7:0]  CELL_FILL     = 8'hFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MUL_X,
		ST_MUL_Z,
		ST_INDEX,
		ST_READ,
		ST_BLEND_A,
		ST_BLEND_B
	} state_t;

endpackage

`default_nettype wire

[sv/density_grid_bilinear_sampler.sv]
`default_nettype none

// Density grid sampler. Commands enter on start while busy is low; each command gives one
// result word, shown for exactly one cycle with done high, and the receiver must take it
// then since it cannot stall the block. A cell write, an unused code and a sample on an
// empty grid return their word in the cycle after acceptance without raising busy, so
// such commands can follow each other every cycle. A sample keeps busy high until its
// result word: the two grid coordinates share one multiplier, the four neighbour cells
// come one at a time from the single-port grid RAM, whose read data is registered, and
// the row blend reuses one multiplier for the top and bottom rows. A clear writes 255
// into every one of the MAX_WIDTH*MAX_HEIGHT cells, one per cycle, and returns its word
// at the end. The same clearing pass runs right after reset, with busy high and no
// result word; configuration writes are taken at any time and should be made only while
// the block is idle.
module density_grid_bilinear_sampler #(
	parameter int MAX_WIDTH  = dgbs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dgbs_pkg::DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dgbs_pkg::func_t     func,
	input  logic signed [23:0]  world_x,
	input  logic signed [23:0]  world_z,
	input  logic signed [10:0]  cell_x,
	input  logic signed [10:0]  cell_y,
	input  logic [7:0]          write_value,
	output logic                done,
	output logic [15:0]         density,
	output logic                write_done,
	input  logic                cfg_we,
	input  dgbs_pkg::reg_idx_t  cfg_addr,
	input  logic [18:0]         cfg_wdata
);
	import dgbs_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [8:0] clamp_idx(input logic signed [19:0] v,
			input logic [8:0] n);
		logic [8:0] r;
		priority if (v < 20'sd0) begin
			r = 9'd0;
		end else if (v >= signed'({11'b0, n})) begin
			r = n - 9'd1;
		end else begin
			r = v[8:0];
		end
		return r;
	endfunction

	// configuration
	logic [8:0]  grid_width_q;
	logic [8:0]  grid_height_q;
	logic [18:0] inv_cell_q;

	// control
	state_t          state_q, state_d;
	logic [AW-1:0]   clr_cnt_q;
	logic            clr_report_q;
	logic [2:0]      cnt_q;
	logic            done_q;
	logic [15:0]     density_q;
	logic            write_done_q;

	// datapath
	logic signed [23:0] wx_q, wz_q;
	logic signed [42:0] px_q, pz_q;
	logic [8:0]         xa_q, xb_q, ya_q, yb_q;
	logic [7:0]         tx_q, ty_q;
	logic [15:0]        top_q, bot_q;
	logic [23:0]        acc_q;

	// grid memory
	logic [7:0]    grid_mem [DEPTH];
	logic [7:0]    mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	logic               accept;
	logic [8:0]         act_w, act_h;
	logic               grid_empty;
	logic               wr_hit;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [8:0]         x_sel, y_sel;
	logic [18:0]        inv_eff;
	logic signed [23:0] mul_a;
	logic signed [43:0] mul_p;
	logic signed [19:0] x0, x1, z0, z1;
	logic [1:0]         rk;
	logic [8:0]         cell_w;
	logic [16:0]        cell_prod;
	logic [15:0]        blend_op;
	logic [8:0]         blend_w;
	logic [24:0]        blend_mul;
	logic [23:0]        blend_sum;
	logic               clr_last;
	logic               res_valid;
	logic [15:0]        res_density;
	logic               res_wdone;

	assign accept = start && (state_q == ST_IDLE);

	assign act_w = (int'(grid_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : grid_width_q;
	assign act_h = (int'(grid_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : grid_height_q;
	assign grid_empty = (act_w == 9'd0) || (act_h == 9'd0);

	assign wr_hit = (func == FUNC_WRITE) && !cell_x[10] && !cell_y[10]
		&& (cell_x[9:0] < {1'b0, act_w}) && (cell_y[9:0] < {1'b0, act_h});
	assign wr_addr = AW'(AW'(cell_y[8:0]) * AW'(MAX_WIDTH) + AW'(cell_x[8:0]));

	// neighbour order: (xa,ya) (xb,ya) (xa,yb) (xb,yb)
	assign x_sel   = cnt_q[0] ? xb_q : xa_q;
	assign y_sel   = cnt_q[1] ? yb_q : ya_q;
	assign rd_addr = AW'(AW'(y_sel) * AW'(MAX_WIDTH) + AW'(x_sel));

	assign inv_eff = (inv_cell_q == 19'd0) ? INV_CELL_UNIT : inv_cell_q;
	assign mul_a   = (state_q == ST_MUL_X) ? wx_q : wz_q;
	assign mul_p   = mul_a * signed'({1'b0, inv_eff});

	assign x0 = 20'($signed(px_q[42:24]));
	assign x1 = x0 + 20'sd1;
	assign z0 = 20'($signed(pz_q[42:24]));
	assign z1 = z0 + 20'sd1;

	// cell read in the previous cycle
	assign rk        = 2'(cnt_q - 3'd1);
	assign cell_w    = rk[0] ? {1'b0, tx_q} : (9'd256 - {1'b0, tx_q});
	assign cell_prod = mem_rd_q * cell_w;

	assign blend_op  = (state_q == ST_BLEND_A) ? top_q : bot_q;
	assign blend_w   = (state_q == ST_BLEND_A) ? (9'd256 - {1'b0, ty_q}) : {1'b0, ty_q};
	assign blend_mul = blend_op * blend_w;
	assign blend_sum = acc_q + blend_mul[23:0];

	assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_SAMPLE && !grid_empty) begin
						state_d = ST_MUL_X;
					end else if (func == FUNC_CLEAR) begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL_X:   state_d = ST_MUL_Z;
			ST_MUL_Z:   state_d = ST_INDEX;
			ST_INDEX:   state_d = ST_READ;
			ST_READ: begin
				if (cnt_q == 3'd4) begin
					state_d = ST_BLEND_A;
				end
			end
			ST_BLEND_A: state_d = ST_BLEND_B;
			ST_BLEND_B: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs: memory port and result word
	always_comb begin
		busy        = (state_q != ST_IDLE);
		mem_we      = 1'b0;
		mem_addr    = rd_addr;
		mem_wdata   = write_value;
		res_valid   = 1'b0;
		res_density = 16'd0;
		res_wdone   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mem_addr = wr_addr;
				mem_we   = accept && wr_hit;
				if (accept) begin
					unique case (func)
						FUNC_SAMPLE: begin
							res_valid   = grid_empty;
							res_density = FULL_DENSITY;
						end
						FUNC_WRITE: begin
							res_valid = 1'b1;
							res_wdone = wr_hit;
						end
						FUNC_NOP:   res_valid = 1'b1;
						default:    res_valid = 1'b0;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_cnt_q;
				mem_wdata = CELL_FILL;
				res_valid = clr_last && clr_report_q;
			end
			ST_BLEND_B: begin
				res_valid   = 1'b1;
				res_density = blend_sum[23:8];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_addr] <= mem_wdata;
		end
		mem_rd_q <= grid_mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 9'd0;
			grid_height_q <= 9'd0;
			inv_cell_q    <= INV_CELL_UNIT;
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			clr_report_q  <= 1'b0;
			cnt_q         <= 3'd0;
			done_q        <= 1'b0;
			density_q     <= 16'd0;
			write_done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_GRID_WIDTH:    grid_width_q  <= cfg_wdata[8:0];
					REG_GRID_HEIGHT:   grid_height_q <= cfg_wdata[8:0];
					REG_INV_CELL_SIZE: inv_cell_q    <= cfg_wdata;
					default: ;
				endcase
			end
			state_q      <= state_d;
			done_q       <= res_valid;
			density_q    <= res_density;
			write_done_q <= res_wdone;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
			end
			if (accept && func == FUNC_CLEAR) begin
				clr_report_q <= 1'b1;
			end else if (state_q == ST_CLEAR && clr_last) begin
				clr_report_q <= 1'b0;
			end
			if (state_q == ST_READ) begin
				cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wx_q <= world_x;
			wz_q <= world_z;
		end
		if (state_q == ST_MUL_X) begin
			px_q <= mul_p[42:0];
		end
		if (state_q == ST_MUL_Z) begin
			pz_q <= mul_p[42:0];
		end
		if (state_q == ST_INDEX) begin
			xa_q <= clamp_idx(x0, act_w);
			xb_q <= clamp_idx(x1, act_w);
			ya_q <= clamp_idx(z0, act_h);
			yb_q <= clamp_idx(z1, act_h);
			tx_q <= px_q[23:16];
			ty_q <= pz_q[23:16];
		end
		// accumulate the two row blends as cells arrive
		if (state_q == ST_READ && cnt_q != 3'd0) begin
			if (!rk[1]) begin
				top_q <= rk[0] ? top_q + cell_prod[15:0] : cell_prod[15:0];
			end else begin
				bot_q <= rk[0] ? bot_q + cell_prod[15:0] : cell_prod[15:0];
			end
		end
		if (state_q == ST_BLEND_A) begin
			acc_q <= blend_mul[23:0];
		end
	end

	assign done       = done_q;
	assign density    = density_q;
	assign write_done = write_done_q;

endmodule

`default_nettype wire

[sv/dgbs_checker.sv]
`default_nettype none

`include "density_grid_bilinear_sampler_defines.svh"

module dgbs_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire dgbs_pkg::func_t  func,
	input wire logic             done,
	input wire logic [15:0]      density,
	input wire logic             write_done
);
	import dgbs_pkg::*;

	// a write result never carries a density
	`DGBS_ASSERT_SAME(a_write_no_density, done && write_done, density == 16'd0, "write word has density")

	// a landed write comes only from a write accepted the cycle before
	`DGBS_ASSERT_SAME(a_write_done_source, done && write_done, $past(start && !busy && func == FUNC_WRITE), "write_done without write")

	// writes and unused codes answer in the next cycle with zero density
	`DGBS_ASSERT_NEXT(a_quick_result, start && !busy && (func == FUNC_WRITE || func == FUNC_NOP), done && density == 16'd0, "missing quick result word")

	// a sample either answers at once or keeps the block busy
	`DGBS_ASSERT_NEXT(a_sample_progress, start && !busy && func == FUNC_SAMPLE, done || busy, "sample dropped")

	// a clear holds the block busy and gives no word at once
	`DGBS_ASSERT_NEXT(a_clear_busy, start && !busy && func == FUNC_CLEAR, busy && !done, "clear not busy")

endmodule

bind density_grid_bilinear_sampler dgbs_checker u_dgbs_checker (.*);

`default_nettype wire

[tb/density_grid_bilinear_sampler_tb.sv]
`timescale 1ns / 1ps

module density_grid_bilinear_sampler_tb;
	import dgbs_pkg::*;

	localparam int GRID_STRIDE  = DEF_MAX_WIDTH;
	localparam int GRID_CELLS   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int CLEAR_BUDGET = 6;
	localparam int PHASE_WORDS  = 350;
	localparam int SETTING_SPAN = 70;
	localparam reg_idx_t REG_UNUSED = 2'd3;

	typedef struct {
		logic [15:0] density;
		logic        write_done;
	} grid_word_t;

	class density_scoreboard;
		logic [7:0]  cells [0:GRID_CELLS-1];
		int unsigned span_x;
		int unsigned span_y;
		int unsigned inv_raw;
		grid_word_t  pending [$];
		int          errors;
		int          checked;
		int          samples;
		int          landed;
		int          clears;

		function new();
			refill();
			span_x  = 0;
			span_y  = 0;
			inv_raw = 32'(INV_CELL_UNIT);
		endfunction

		function void refill();
			for (int i = 0; i < GRID_CELLS; i++)
				cells[i] = CELL_FILL;
		endfunction

		function void set_reg(reg_idx_t idx, logic [18:0] data);
			case (idx)
				REG_GRID_WIDTH:    span_x  = 32'(data[8:0]);
				REG_GRID_HEIGHT:   span_y  = 32'(data[8:0]);
				REG_INV_CELL_SIZE: inv_raw = 32'(data);
				default: ;
			endcase
		endfunction

		function int unsigned cols();
			return (span_x > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : span_x;
		endfunction

		function int unsigned rows();
			return (span_y > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : span_y;
		endfunction

		function int unsigned clamp(longint v, int unsigned n);
			if (v < 0)
				return 0;
			if (v > longint'(n) - 1)
				return n - 1;
			return 32'(v);
		endfunction

		function logic [15:0] blend(logic signed [23:0] wx, logic signed [23:0] wz);
			int unsigned w, h, inv, tx, ty, xa, xb, ya, yb, top, bot;
			longint px, pz, ix, iz;
			w   = cols();
			h   = rows();
			inv = (inv_raw == 0) ? 32'(INV_CELL_UNIT) : inv_raw;
			if (w == 0 || h == 0)
				return FULL_DENSITY;
			px = longint'(wx) * longint'(inv);
			pz = longint'(wz) * longint'(inv);
			ix = px >>> 24;
			iz = pz >>> 24;
			tx = 32'((px >> 16) & 255);
			ty = 32'((pz >> 16) & 255);
			xa = clamp(ix, w);
			xb = clamp(ix + 1, w);
			ya = clamp(iz, h);
			yb = clamp(iz + 1, h);
			top = cells[ya * GRID_STRIDE + xa] * (256 - tx) + cells[ya * GRID_STRIDE + xb] * tx;
			bot = cells[yb * GRID_STRIDE + xa] * (256 - tx) + cells[yb * GRID_STRIDE + xb] * tx;
			return 16'((top * (256 - ty) + bot * ty) >> 8);
		endfunction

		// accepted command word: update the grid copy and queue its result
		function void note(func_t f, logic signed [23:0] wx, logic signed [23:0] wz,
				logic signed [10:0] cx, logic signed [10:0] cy, logic [7:0] v);
			grid_word_t exp_word;
			exp_word.density    = 16'd0;
			exp_word.write_done = 1'b0;
			case (f)
				FUNC_SAMPLE: begin
					exp_word.density = blend(wx, wz);
					samples++;
				end
				FUNC_WRITE: begin
					if (int'(cx) >= 0 && int'(cy) >= 0 && int'(cx) < int'(cols())
							&& int'(cy) < int'(rows())) begin
						cells[int'(cy) * GRID_STRIDE + int'(cx)] = v;
						exp_word.write_done = 1'b1;
						landed++;
					end
				end
				FUNC_CLEAR: begin
					refill();
					clears++;
				end
				default: ;
			endcase
			pending = {pending, exp_word};
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void check(logic [15:0] d, logic wd);
			grid_word_t exp_word;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected result word: density %0d write_done %0b", d, wd));
				return;
			end
			exp_word = pending.pop_front();
			checked++;
			if (d !== exp_word.density || wd !== exp_word.write_done)
				flag($sformatf("result mismatch: expected density %0d write_done %0b, got %0d %0b",
					exp_word.density, exp_word.write_done, d, wd));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	func_t              func;
	logic signed [23:0] world_x;
	logic signed [23:0] world_z;
	logic signed [10:0] cell_x;
	logic signed [10:0] cell_y;
	logic [7:0]         write_value;
	logic               done;
	logic [15:0]        density;
	logic               write_done;
	logic               cfg_we;
	reg_idx_t           cfg_addr;
	logic [18:0]        cfg_wdata;

	density_scoreboard sb;
	int                sender_idle;
	int                words_sent;
	int                clears_sent;
	int                settings;
	longint            cycles;

	density_grid_bilinear_sampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.world_x(world_x),
		.world_z(world_z),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.write_value(write_value),
		.done(done),
		.density(density),
		.write_done(write_done),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycles, sb.pending.size());
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(func, world_x, world_z, cell_x, cell_y, write_value);
			if (done)
				sb.check(density, write_done);
		end
	end

	task automatic send(func_t f, logic signed [23:0] wx, logic signed [23:0] wz,
			logic signed [10:0] cx, logic signed [10:0] cy, logic [7:0] v);
		@(negedge clk);
		start       = 1'b1;
		func        = f;
		world_x     = wx;
		world_z     = wz;
		cell_x      = cx;
		cell_y      = cy;
		write_value = v;
		do @(posedge clk); while (busy);
		words_sent++;
		if (f == FUNC_CLEAR)
			clears_sent++;
		if (sender_idle > 0 && $urandom_range(0, 99) < sender_idle) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
	endtask

	// hold off until every expected word has come back and the block is idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [18:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int unsigned w, int unsigned h, int unsigned inv);
		drain();
		// upper data bits are don't-care for the 9-bit size registers
		cfg_write(REG_GRID_WIDTH, {10'($urandom_range(0, 1023)), w[8:0]});
		cfg_write(REG_GRID_HEIGHT, {10'($urandom_range(0, 1023)), h[8:0]});
		cfg_write(REG_INV_CELL_SIZE, inv[18:0]);
		settings++;
	endtask

	function automatic int unsigned pick_span();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 256;
			3: return $urandom_range(257, 511);
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	function automatic int unsigned pick_inv();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65536;
			2: return 262144;
			3: return $urandom_range(1, 262144);
			default: return $urandom_range(16384, 131072);
		endcase
	endfunction

	// grid coordinate (8 fraction bits) back to a world position
	function automatic logic signed [23:0] to_world(longint g, int unsigned inv);
		longint wv;
		wv = g * 65536 / longint'(inv);
		if (wv > 8388607)
			wv = 8388607;
		if (wv < -8388608)
			wv = -8388608;
		return 24'(wv);
	endfunction

	task automatic run_random(int count);
		int unsigned        aw, ah, ie, r;
		func_t              f;
		logic signed [23:0] wx, wz;
		logic signed [10:0] cx, cy;
		logic [7:0]         v;
		for (int i = 0; i < count; i++) begin
			if (i % SETTING_SPAN == 0)
				configure(pick_span(), pick_span(), pick_inv());
			aw = sb.cols();
			ah = sb.rows();
			if (aw == 0)
				aw = 4;
			if (ah == 0)
				ah = 4;
			ie = (sb.inv_raw == 0) ? 32'(INV_CELL_UNIT) : sb.inv_raw;
			wx = 24'($urandom);
			wz = 24'($urandom);
			cx = 11'($urandom);
			cy = 11'($urandom);
			v  = 8'($urandom);
			r  = $urandom_range(0, 99);
			if (clears_sent < CLEAR_BUDGET && $urandom_range(0, 299) == 0)
				f = FUNC_CLEAR;
			else if (r < 6) begin
				f = func_t'($urandom_range(0, 3));
				if (f == FUNC_CLEAR)
					f = FUNC_SAMPLE;
			end else if (r < 10)
				f = FUNC_NOP;
			else if (r < 50) begin
				f  = FUNC_WRITE;
				cx = 11'($urandom_range(0, aw + 1) - 1);
				cy = 11'($urandom_range(0, ah + 1) - 1);
			end else begin
				f  = FUNC_SAMPLE;
				wx = to_world(longint'($urandom_range(0, (aw + 4) * 256)) - 512, ie);
				wz = to_world(longint'($urandom_range(0, (ah + 4) * 256)) - 512, ie);
			end
			send(f, wx, wz, cx, cy, v);
		end
	endtask

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = FUNC_SAMPLE;
		world_x     = '0;
		world_z     = '0;
		cell_x      = '0;
		cell_y      = '0;
		write_value = '0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_GRID_WIDTH;
		cfg_wdata   = '0;
		sender_idle = 0;
		words_sent  = 0;
		clears_sent = 0;
		settings    = 0;
		cycles      = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty grid straight after reset
		send(FUNC_SAMPLE, 24'sd1000, -24'sd1000, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd0, 11'sd0, 8'd7);
		send(FUNC_NOP, 24'sd0, 24'sd0, 11'sd0, 11'sd0, 8'd0);

		configure(4, 3, 65536);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd3, 11'sd2, 8'd17);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd1, 11'sd1, 8'd128);
		send(FUNC_WRITE, 24'sd0, 24'sd0, -11'sd1, 11'sd0, 8'd9);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd4, 11'sd0, 8'd9);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd0, 11'sd3, 8'd9);
		send(FUNC_WRITE, 24'sd0, 24'sd0, -11'sd1024, -11'sd1024, 8'd0);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd1023, 11'sd1023, 8'd255);
		send(FUNC_SAMPLE, 24'sd0, 24'sd0, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_SAMPLE, 24'sd384, 24'sd128, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_SAMPLE, 24'sd8388607, -24'sd8388608, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_SAMPLE, -24'sd256, -24'sd200, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_NOP, 24'sd8388607, 24'sd8388607, 11'sd1023, 11'sd1023, 8'd255);
		send(FUNC_CLEAR, 24'sd0, 24'sd0, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_SAMPLE, 24'sd384, 24'sd128, 11'sd0, 11'sd0, 8'd0);
		drain();
		cfg_write(REG_UNUSED, 19'h7FFFF);

		// oversized grid and zero scale
		configure(511, 300, 0);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd255, 11'sd255, 8'd1);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd256, 11'sd0, 8'd2);
		send(FUNC_SAMPLE, 24'sd8388607, 24'sd8388607, 11'sd0, 11'sd0, 8'd0);
		send(FUNC_SAMPLE, 24'sd65408, 24'sd65408, 11'sd0, 11'sd0, 8'd0);

		configure(2, 2, 262144);
		send(FUNC_WRITE, 24'sd0, 24'sd0, 11'sd1, 11'sd0, 8'd40);
		send(FUNC_SAMPLE, 24'sd64, 24'sd1, 11'sd0, 11'sd0, 8'd0);
		configure(1, 1, 1);
		send(FUNC_SAMPLE, -24'sd8388608, 24'sd8388607, 11'sd0, 11'sd0, 8'd0);

		sender_idle = 35;
		run_random(PHASE_WORDS);
		sender_idle = 48;
		run_random(PHASE_WORDS);
		sender_idle = 0;
		run_random(PHASE_WORDS);
		drain();

		$display("%0d command words sent over %0d register settings, %0d results checked",
			words_sent, settings, sb.checked);
		$display("%0d samples, %0d writes landed, %0d clears, %0d mismatches",
			sb.samples, sb.landed, sb.clears, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/dgbs_pkg.sv
sv/density_grid_bilinear_sampler.sv
sv/dgbs_checker.sv
tb/density_grid_bilinear_sampler_tb.sv
